/* sv/laser_point_to_sample_interpolator_core_macros.svh */
// Assertion macros used by the interpolator job queue.
// Include this header by its bare file name; it has no other dependencies.
`ifndef LASER_POINT_TO_SAMPLE_INTERPOLATOR_CORE_MACROS_SVH
`define LASER_POINT_TO_SAMPLE_INTERPOLATOR_CORE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define LPSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LPSI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lpsi_pkg.sv */
// Types and constants of the laser point to sample interpolator.
// No dependencies; imported by every module of the block but the divider.
`default_nettype none
package lpsi_pkg;

  localparam int unsigned N_W         = 7;   // sub-point count, up to 64
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_FPS    = 3'd0,
    REG_PPS    = 3'd1,
    REG_SR     = 3'd2,
    REG_INV    = 3'd3,
    REG_CCOUNT = 3'd4,
    REG_CMAP   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    CH_X       = 3'd0,
    CH_Y       = 3'd1,
    CH_Z       = 3'd2,
    CH_BLANK   = 3'd3,
    CH_R       = 3'd4,
    CH_G       = 3'd5,
    CH_B       = 3'd6,
    CH_INVALID = 3'd7
  } chan_code_e;

  typedef struct packed {
    logic [9:0]  fps;
    logic [17:0] pps;
    logic [17:0] sr;
    logic [2:0]  inv;
    logic [2:0]  ccount;
    logic [20:0] cmap;
  } cfg_t;

  // One queued job: either a second-counter clear or a point to expand.
  typedef struct packed {
    logic             clr;
    logic [2:0][15:0] tgt;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [N_W-1:0]   n;
  } entry_t;

endpackage
`default_nettype wire

/* sv/laser_point_to_sample_interpolator_core.sv */
// Front: a point takes four 32-bit divisions on one shared divider. Back: a point takes
// a division for the repeat base, then per sub-point a 36-bit division for the repeat
// count, which sets the pace. The queue lets the front take a new point while the back
// is still expanding an earlier one.
// Reset: control state, frame and sample counters and the last position clear to zero,
// registers take their defaults; no clearing pass is needed.
`default_nettype none
module laser_point_to_sample_interpolator_core
  import lpsi_pkg::*;
#(
  parameter int unsigned MAX_SUB_POINTS = 64,
  parameter int unsigned MAX_CHANNELS   = 7
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration write port.
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [20:0]  cfg_wdata_i,
  // Input request stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata, low bit up: pos_x, pos_y, pos_z, red, green, blue, point_index, point_total
  input  wire logic [103:0] s_axis_tdata,
  // tuser: command (0 point, 1 end of frame)
  input  wire logic [0:0]   s_axis_tuser,
  // Output sample stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata, low bit up: chan0 .. chan6, repeat_count, zero padding
  output logic [135:0]      m_axis_tdata,
  output logic              m_axis_tlast,   // last sub-point of the input point
  // tuser: bad_signal
  output logic [0:0]        m_axis_tuser
);
  cfg_t   cfg_q;
  entry_t push_entry, head_entry;
  logic   push, pop, full, empty;
  logic [6:0][15:0] chan;
  logic [17:0]      rpt;
  logic             last, bad;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fps    <= 10'd30;
      cfg_q.pps    <= 18'd30000;
      cfg_q.sr     <= 18'd48000;
      cfg_q.inv    <= 3'd0;
      cfg_q.ccount <= 3'd5;
      cfg_q.cmap   <= 21'd27400;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FPS:    cfg_q.fps    <= cfg_wdata_i[9:0];
        REG_PPS:    cfg_q.pps    <= cfg_wdata_i[17:0];
        REG_SR:     cfg_q.sr     <= cfg_wdata_i[17:0];
        REG_INV:    cfg_q.inv    <= cfg_wdata_i[2:0];
        REG_CCOUNT: cfg_q.ccount <= cfg_wdata_i[2:0];
        REG_CMAP:   cfg_q.cmap   <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // The front classifies each request and works out how many sub-points it gets.
  lpsi_front #(.MAX_SUB_POINTS(MAX_SUB_POINTS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser[0]),
    .pos_x_i(s_axis_tdata[15:0]), .pos_y_i(s_axis_tdata[31:16]),
    .pos_z_i(s_axis_tdata[47:32]), .red_i(s_axis_tdata[55:48]),
    .green_i(s_axis_tdata[63:56]), .blue_i(s_axis_tdata[71:64]),
    .idx_i(s_axis_tdata[87:72]), .total_i(s_axis_tdata[103:88]),
    .push_o(push), .entry_o(push_entry), .full_i(full)
  );

  // Jobs wait here so the front can take new requests while the back is expanding.
  lpsi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_entry), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(head_entry)
  );

  // The back interpolates each sub-point and holds it in the output register.
  lpsi_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .entry_i(head_entry), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .chan_o(chan), .repeat_o(rpt), .last_o(last), .bad_o(bad)
  );

  assign m_axis_tdata = {6'd0, rpt, chan};
  assign m_axis_tlast = last;
  assign m_axis_tuser = bad;
endmodule
`default_nettype wire

/* sv/lpsi_div.sv */
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on nothing; used by the front and back parts.
`default_nettype none
module lpsi_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 18
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   trial;

  assign trial  = {rem_q, quo_q[NW-1]};
  assign busy_o = start_i | (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_q <= DW'(trial - {1'b0, den_q});
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

/* sv/lpsi_queue.sv */
// Short job queue between the front and back parts.
// Depends on lpsi_pkg and the assertion macro header.
`default_nettype none
`include "laser_point_to_sample_interpolator_core_macros.svh"
module lpsi_queue
  import lpsi_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        empty_o,
  output entry_t      data_o
);
  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `LPSI_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `LPSI_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `LPSI_ASSERT_NXT(a_fill_tracks, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "fill count lost a push")
endmodule
`default_nettype wire

/* sv/lpsi_front.sv */
// Front part: accepts points and frame markers, computes sub-point counts.
// Depends on lpsi_pkg and lpsi_div.
`default_nettype none
module lpsi_front
  import lpsi_pkg::*;
#(
  parameter int unsigned MAX_SUB_POINTS = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         cmd_i,
  input  wire logic [15:0]  pos_x_i,
  input  wire logic [15:0]  pos_y_i,
  input  wire logic [15:0]  pos_z_i,
  input  wire logic [7:0]   red_i,
  input  wire logic [7:0]   green_i,
  input  wire logic [7:0]   blue_i,
  input  wire logic [15:0]  idx_i,
  input  wire logic [15:0]  total_i,
  output logic              push_o,
  output entry_t            entry_o,
  input  wire logic         full_i
);
  typedef enum logic [2:0] {
    F_IDLE, F_DIV1, F_MOD1, F_DIV2, F_MOD2, F_PUSH
  } state_e;

  state_e      state_q;
  logic [9:0]  fis_q;
  logic [15:0] idx_q, total_q;
  logic [17:0] base_q, rest_q;
  entry_t      entry_q;
  logic        div_start_q;
  logic [31:0] div_num_q;
  logic [17:0] div_den_q;
  logic        div_busy;
  logic [31:0] div_quo;
  logic [17:0] div_rem;

  logic [10:0] f_next;
  logic [19:0] m1;
  logic [31:0] m2;
  logic [10:0] sum1;
  logic [16:0] sum2;
  logic [17:0] share;
  logic [17:0] n_full;
  logic [15:0] t_x, t_y, t_z;

  lpsi_div #(.NW(32), .DW(18)) u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(div_num_q), .den_i(div_den_q),
    .busy_o(div_busy), .quo_o(div_quo), .rem_o(div_rem)
  );

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign entry_o    = entry_q;

  always_comb begin
    f_next = {1'b0, fis_q} + 11'd1;
    // The remainder is taken straight from the divider, as it is registered in the same cycle.
    m1     = fis_q * div_rem[9:0];
    m2     = idx_q * div_rem[15:0];
    sum1   = {1'b0, div_rem[9:0]} + {1'b0, rest_q[9:0]};
    share  = base_q + 18'(sum1 >= {1'b0, cfg_i.fps});
    sum2   = {1'b0, div_rem[15:0]} + {1'b0, rest_q[15:0]};
    n_full = base_q + 18'(sum2 >= {1'b0, total_q});
    t_x    = cfg_i.inv[0] ? 16'(16'd0 - pos_x_i) : pos_x_i;
    t_y    = cfg_i.inv[1] ? 16'(16'd0 - pos_y_i) : pos_y_i;
    t_z    = cfg_i.inv[2] ? 16'(16'd0 - pos_z_i) : pos_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      fis_q       <= '0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            idx_q         <= idx_i;
            total_q       <= total_i;
            entry_q.clr   <= cmd_i;
            entry_q.tgt   <= {t_z, t_y, t_x};
            entry_q.red   <= red_i;
            entry_q.green <= green_i;
            entry_q.blue  <= blue_i;
            entry_q.n     <= '0;
            if (cmd_i) begin
              // End of frame; wrapping the frame count also restarts the second.
              if (f_next >= {1'b0, cfg_i.fps}) begin
                fis_q   <= '0;
                state_q <= F_PUSH;
              end else begin
                fis_q <= f_next[9:0];
              end
            end else if (cfg_i.fps != '0 && total_i != '0) begin
              div_num_q   <= {14'd0, cfg_i.pps};
              div_den_q   <= {8'd0, cfg_i.fps};
              div_start_q <= 1'b1;
              state_q     <= F_DIV1;
            end
          end
        end
        F_DIV1: begin
          if (!div_busy) begin
            base_q      <= div_quo[17:0];
            rest_q      <= {8'd0, div_rem[9:0]};
            div_num_q   <= {12'd0, m1};
            div_den_q   <= {8'd0, cfg_i.fps};
            div_start_q <= 1'b1;
            state_q     <= F_MOD1;
          end
        end
        F_MOD1: begin
          if (!div_busy) begin
            div_num_q   <= {14'd0, share};
            div_den_q   <= {2'd0, total_q};
            div_start_q <= 1'b1;
            state_q     <= F_DIV2;
          end
        end
        F_DIV2: begin
          if (!div_busy) begin
            base_q      <= div_quo[17:0];
            rest_q      <= {2'd0, div_rem[15:0]};
            div_num_q   <= m2;
            div_den_q   <= {2'd0, total_q};
            div_start_q <= 1'b1;
            state_q     <= F_MOD2;
          end
        end
        F_MOD2: begin
          if (!div_busy) begin
            if (n_full == '0) begin
              state_q <= F_IDLE;
            end else begin
              entry_q.n <= (n_full > 18'(MAX_SUB_POINTS)) ? N_W'(MAX_SUB_POINTS)
                                                          : n_full[N_W-1:0];
              state_q   <= F_PUSH;
            end
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/lpsi_back.sv */
// Back part: expands queued points into interpolated sample sets.
// Depends on lpsi_pkg and lpsi_div.
`default_nettype none
module lpsi_back
  import lpsi_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          empty_i,
  input  wire entry_t        entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [6:0][15:0]   chan_o,
  output logic [17:0]        repeat_o,
  output logic               last_o,
  output logic               bad_o
);
  typedef enum logic [2:0] {
    B_IDLE, B_BASE, B_SUB, B_WAIT, B_OUT
  } state_e;

  state_e           state_q;
  entry_t           cur_q;
  logic [2:0][15:0] prev_q, d_q;
  logic [N_W-1:0]   p_q;
  logic [17:0]      pts_q, base_sr_q, rest_sr_q;
  logic             out_valid_q;
  logic [6:0][15:0] chan_q;
  logic [17:0]      repeat_q;
  logic             last_q, bad_q;

  logic             sr_start_q;
  logic [35:0]      sr_num_q;
  logic             sr_busy;
  logic [35:0]      sr_quo;
  logic [17:0]      sr_rem;

  logic             ax_start_q;
  logic [2:0][21:0] ax_num_q;
  logic [2:0]       ax_neg_q;
  logic [2:0]       ax_busy;
  logic [2:0][21:0] ax_quo;
  logic [2:0][N_W-1:0] ax_rem;

  logic [35:0]      m3;
  logic [18:0]      sum3;
  logic [17:0]      rpt;
  logic [2:0][15:0] pos;
  logic [2:0][23:0] prod;
  logic [15:0]      cr, cg, cb, blank;
  logic [2:0]       used;
  logic [6:0][15:0] chan_d;
  logic             bad_d;
  logic             load;

  lpsi_div #(.NW(36), .DW(18)) u_sr_div (
    .clk_i, .rst_ni, .start_i(sr_start_q), .num_i(sr_num_q), .den_i(cfg_i.pps),
    .busy_o(sr_busy), .quo_o(sr_quo), .rem_o(sr_rem)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    lpsi_div #(.NW(22), .DW(N_W)) u_ax_div (
      .clk_i, .rst_ni, .start_i(ax_start_q), .num_i(ax_num_q[a]), .den_i(cur_q.n),
      .busy_o(ax_busy[a]), .quo_o(ax_quo[a]), .rem_o(ax_rem[a])
    );
  end

  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign load        = (state_q == B_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign chan_o      = chan_q;
  assign repeat_o    = repeat_q;
  assign last_o      = last_q;
  assign bad_o       = bad_q;

  always_comb begin
    m3   = pts_q * rest_sr_q;
    sum3 = {1'b0, sr_rem} + {1'b0, rest_sr_q};
    rpt  = (cfg_i.pps == '0) ? '0 : base_sr_q + 18'(sum3 >= {1'b0, cfg_i.pps});
    for (int a = 0; a < 3; a++) begin
      prod[a] = $signed(d_q[a]) * $signed({1'b0, p_q});
      pos[a]  = prev_q[a] + (ax_neg_q[a] ? 16'(22'd0 - ax_quo[a]) : ax_quo[a][15:0]);
    end
    cr    = {1'b0, cur_q.red, 7'd0};
    cg    = {1'b0, cur_q.green, 7'd0};
    cb    = {1'b0, cur_q.blue, 7'd0};
    blank = ((cur_q.red | cur_q.green | cur_q.blue) != '0) ? 16'h7FFF : 16'h0000;
    used  = (cfg_i.ccount < 3'(MAX_CHANNELS)) ? cfg_i.ccount : 3'(MAX_CHANNELS);
    bad_d = 1'b0;
    for (int j = 0; j < 7; j++) begin
      chan_d[j] = '0;
      if (3'(j) < used) begin
        case (chan_code_e'(cfg_i.cmap[3*j +: 3]))
          CH_X:     chan_d[j] = pos[0];
          CH_Y:     chan_d[j] = pos[1];
          CH_Z:     chan_d[j] = pos[2];
          CH_BLANK: chan_d[j] = blank;
          CH_R:     chan_d[j] = cr;
          CH_G:     chan_d[j] = cg;
          CH_B:     chan_d[j] = cb;
          default: begin
            chan_d[j] = '0;
            bad_d     = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      prev_q      <= '0;
      pts_q       <= '0;
      out_valid_q <= 1'b0;
      sr_start_q  <= 1'b0;
      ax_start_q  <= 1'b0;
    end else begin
      sr_start_q <= 1'b0;
      ax_start_q <= 1'b0;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            cur_q <= entry_i;
            if (entry_i.clr) begin
              pts_q <= '0;
            end else begin
              for (int a = 0; a < 3; a++) begin
                d_q[a] <= entry_i.tgt[a] - prev_q[a];
              end
              p_q <= N_W'(1);
              if (cfg_i.pps == '0) begin
                base_sr_q <= '0;
                rest_sr_q <= '0;
                state_q   <= B_SUB;
              end else begin
                sr_num_q   <= {18'd0, cfg_i.sr};
                sr_start_q <= 1'b1;
                state_q    <= B_BASE;
              end
            end
          end
        end
        B_BASE: begin
          if (!sr_busy) begin
            base_sr_q <= sr_quo[17:0];
            rest_sr_q <= sr_rem;
            state_q   <= B_SUB;
          end
        end
        B_SUB: begin
          sr_num_q   <= m3;
          sr_start_q <= 1'b1;
          for (int a = 0; a < 3; a++) begin
            ax_neg_q[a] <= prod[a][23];
            ax_num_q[a] <= prod[a][23] ? 22'(24'd0 - prod[a]) : prod[a][21:0];
          end
          ax_start_q <= 1'b1;
          state_q    <= B_WAIT;
        end
        B_WAIT: begin
          if (!sr_busy && (ax_busy == '0)) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (load) begin
            chan_q   <= chan_d;
            repeat_q <= rpt;
            last_q   <= (p_q == cur_q.n);
            bad_q    <= bad_d;
            pts_q    <= pts_q + 1'b1;
            if (p_q == cur_q.n) begin
              prev_q  <= cur_q.tgt;
              state_q <= B_IDLE;
            end else begin
              p_q     <= p_q + 1'b1;
              state_q <= B_SUB;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* test/laser_point_to_sample_interpolator_core_tb.sv */
// Self-checking testbench for the laser point to sample interpolator core.
// Depends on lpsi_pkg and the core; a scoreboard class predicts sample sets per point.
`timescale 1ns / 100ps
`default_nettype none

module laser_point_to_sample_interpolator_core_tb;
  import lpsi_pkg::*;

  localparam int unsigned SUB_LIMIT = 64;
  localparam int unsigned CHAN_LIMIT = 7;
  localparam int unsigned IDLE_LIMIT = 20000;

  // One expected sample set.
  typedef struct {
    logic [6:0][15:0] chan;
    logic [17:0] repeats;
    logic last;
    logic bad;
  } sample_set_t;

  // Predicts sample sets from accepted requests and checks the output stream.
  class sample_scoreboard;
    bit [9:0]  fps;
    bit [17:0] pps;
    bit [17:0] srate;
    bit [2:0]  inv;
    bit [2:0]  ccount;
    bit [20:0] cmap;
    bit [9:0]  frame_idx;
    bit [17:0] sec_points;
    bit [15:0] last_pos [3];
    sample_set_t pending[$];
    int mismatches;
    int checked;

    function new();
      fps = 30; pps = 30000; srate = 48000; inv = 0; ccount = 5; cmap = 27400;
      frame_idx = 0; sec_points = 0;
      foreach (last_pos[a]) last_pos[a] = 0;
      mismatches = 0; checked = 0;
    endfunction

    function void set_reg(reg_idx_e idx, bit [20:0] v);
      case (idx)
        REG_FPS:    fps = v[9:0];
        REG_PPS:    pps = v[17:0];
        REG_SR:     srate = v[17:0];
        REG_INV:    inv = v[2:0];
        REG_CCOUNT: ccount = v[2:0];
        REG_CMAP:   cmap = v;
        default: ;
      endcase
    endfunction

    // Part idx of an even split of total over groups.
    function longint unsigned even_part(longint unsigned total, longint unsigned groups,
                                        longint unsigned idx);
      longint unsigned base, rest;
      if (groups == 0) return 0;
      base = total / groups;
      rest = total % groups;
      if ((idx * rest) % groups > ((idx + 1) * rest) % groups) return base + 1;
      return base;
    endfunction

    function void note_request(bit eof, bit [103:0] d);
      longint unsigned share, n, used;
      bit [15:0] tgt [3];
      bit [15:0] delta [3];
      bit [15:0] vals [8];
      bit [15:0] cr, cg, cb, blank;
      longint signed q;
      bit [2:0] code;
      sample_set_t s;
      if (eof) begin
        if (longint'(frame_idx) + 1 >= fps) begin
          frame_idx = 0;
          sec_points = 0;
        end else begin
          frame_idx = frame_idx + 10'd1;
        end
        return;
      end
      share = even_part(pps, fps, frame_idx);
      n = even_part(share, d[103:88], d[87:72]);
      if (n > SUB_LIMIT) n = SUB_LIMIT;
      if (n == 0) return;
      for (int a = 0; a < 3; a++) begin
        tgt[a] = d[16*a +: 16];
        if (inv[a]) tgt[a] = -tgt[a];
        delta[a] = tgt[a] - last_pos[a];
      end
      cr = {1'b0, d[55:48], 7'd0};
      cg = {1'b0, d[63:56], 7'd0};
      cb = {1'b0, d[71:64], 7'd0};
      blank = (cr | cg | cb) != 0 ? 16'd32767 : 16'd0;
      used = ccount < CHAN_LIMIT ? ccount : CHAN_LIMIT;
      for (longint unsigned p = 1; p <= n; p++) begin
        for (int a = 0; a < 3; a++) begin
          // SystemVerilog division of signed integers truncates toward zero.
          q = (longint'($signed(delta[a])) * longint'(p)) / longint'(n);
          vals[a] = last_pos[a] + q[15:0];
        end
        vals[3] = blank; vals[4] = cr; vals[5] = cg; vals[6] = cb; vals[7] = 0;
        s.bad = 0;
        for (int j = 0; j < 7; j++) begin
          if (j >= used) begin
            s.chan[j] = 0;
          end else begin
            code = cmap[3*j +: 3];
            if (code == CH_INVALID) s.bad = 1;
            s.chan[j] = vals[code];
          end
        end
        s.repeats = 18'(even_part(srate, pps, sec_points));
        s.last = (p == n);
        pending.push_back(s);
        sec_points = sec_points + 18'd1;
      end
      foreach (last_pos[a]) last_pos[a] = tgt[a];
    endfunction

    function void check_result(bit [135:0] d, bit last, bit bad);
      sample_set_t e;
      bit ok;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected sample set %h", d);
        return;
      end
      e = pending.pop_front();
      ok = (d[111:0] == e.chan) && (d[129:112] == e.repeats) && (d[135:130] == 0)
           && (last == e.last) && (bad == e.bad);
      if (!ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: sample set mismatch: expected chan %h rep %0d last %b bad %b, got chan %h rep %0d last %b bad %b",
                   e.chan, e.repeats, e.last, e.bad, d[111:0], d[129:112], last, bad);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_idx_i = 0;
  logic [20:0]  cfg_wdata_i = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = 0;
  logic [0:0]   s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [0:0]   m_axis_tuser;

  laser_point_to_sample_interpolator_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  sample_scoreboard board = new();

  // Control knobs shared between the driver and the receiver.
  bit sender_idles = 1;
  bit receiver_idles = 1;
  int hold_receiver = 0;
  int idle_cycles = 0;
  int requests_sent = 0;

  // Receiver: random stall bursts, plus one long hold-off requested by the sender side.
  initial begin
    int burst;
    forever begin
      @(negedge clk_i);
      if (hold_receiver > 0) begin
        m_axis_tready <= 0;
        hold_receiver--;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        m_axis_tready <= 0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Sample the output stream and count cycles in which nothing moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Hands one request to the block and waits until it is accepted.
  task automatic send_request(bit eof, bit [103:0] d);
    int burst;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      burst = $urandom_range(1, 4);
      s_axis_tvalid <= 0;
      repeat (burst) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    s_axis_tuser <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(eof, d);
    requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic bit [103:0] pack_point(bit [15:0] x, bit [15:0] y, bit [15:0] z,
                                            bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                            bit [15:0] idx, bit [15:0] total);
    return {total, idx, b, g, r, z, y, x};
  endfunction

  // Lets every expected sample set arrive, then a margin for points that yield nothing.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [20:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    board.set_reg(idx, v);
  endtask

  // Writes the frame rate, point rate and sample rate registers.
  task automatic set_rates(int f, int pp, int sr);
    write_reg(REG_FPS, f);
    write_reg(REG_PPS, pp);
    write_reg(REG_SR, sr);
  endtask

  task automatic random_frames(int count, int max_total);
    int total;
    bit [103:0] d;
    while (count > 0) begin
      total = $urandom_range(1, max_total);
      for (int i = 0; i < total && count > 0; i++) begin
        // Mostly in-frame indexes; now and then an index past the count.
        d = pack_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       ($urandom_range(0, 9) == 0) ? $urandom : i, total);
        if ($urandom_range(0, 15) == 0) d[103:88] = $urandom;
        send_request(0, d);
        count--;
      end
      send_request(1, $urandom);
    end
  endtask

  initial begin
    bit [103:0] d;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed part under reset defaults: 1000 points per frame, split over 100 locations.
    send_request(0, pack_point(16'h7FFF, 16'h8000, 0, 8'hFF, 0, 8'h01, 0, 100));
    send_request(0, pack_point(16'h8000, 16'h7FFF, 16'hFFFF, 0, 0, 0, 1, 100));
    send_request(0, pack_point(0, 0, 0, 0, 8'hFF, 0, 99, 100));
    send_request(0, pack_point(16'h1234, 16'h5678, 16'h9ABC, 1, 2, 3, 65535, 65535));
    send_request(0, pack_point(16'h0001, 16'hFFFF, 16'h7FFF, 8'hAA, 8'h55, 8'hFF, 0, 1));
    send_request(1, 0);
    drain();

    // Negation, all channels with an invalid code and a short frame budget.
    write_reg(REG_INV, 7);
    write_reg(REG_CCOUNT, 7);
    write_reg(REG_CMAP, {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1});
    set_rates(3, 50, 192000);
    send_request(0, pack_point(16'h8000, 16'h7FFF, 16'h0001, 8'hFF, 8'hFF, 8'hFF, 0, 4));
    send_request(0, pack_point(16'h4000, 16'hC000, 16'h8000, 0, 0, 0, 1, 4));
    send_request(0, pack_point(0, 0, 0, 8'h80, 0, 0, 3, 4));
    send_request(1, 0);
    send_request(0, pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1, 1, 0, 2));
    send_request(1, 0);
    send_request(1, 0);
    send_request(0, pack_point(16'h8000, 16'h8000, 16'h8000, 0, 0, 1, 0, 1));
    drain();

    // Zero divisors and zero channels in use.
    write_reg(REG_CCOUNT, 0);
    set_rates(0, 0, 0);
    send_request(0, pack_point(16'h1111, 16'h2222, 16'h3333, 4, 5, 6, 0, 1));
    send_request(1, 0);
    drain();
    write_reg(REG_FPS, 1000);
    write_reg(REG_PPS, 200000);
    send_request(0, pack_point(16'h0F0F, 16'hF0F0, 16'h00FF, 9, 9, 9, 0, 1));
    send_request(0, pack_point(16'h0F0F, 16'hF0F0, 16'h00FF, 9, 9, 9, 0, 0));
    drain();

    // Random part over several settings; small frames keep sub-point counts moderate.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_INV, $urandom_range(0, 7));
      write_reg(REG_CCOUNT, (phase == 0) ? 7 : $urandom_range(0, 7));
      write_reg(REG_CMAP, (phase == 1) ? 21'h1FFFFF : $urandom_range(0, 21'h1FFFFF));
      case (phase)
        0: set_rates(1000, 200000, 192000);
        1: set_rates(1, 30, 1);
        default: set_rates($urandom_range(1, 10), $urandom_range(10, 400),
                           $urandom_range(1, 192000));
      endcase
      if (phase == 2) begin
        // Long receiver hold-off while requests keep coming, so the block backs up.
        hold_receiver = 400;
      end
      if (phase == 5) begin
        sender_idles = 0;
        receiver_idles = 0;
      end
      random_frames(50, 6);
      drain();
    end

    $display("Sent %0d requests over several register settings and checked %0d sample sets.",
             requests_sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d sample sets missing.", board.mismatches,
               board.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: ends the run if nothing is accepted for too long.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Timeout with %0d sample sets outstanding.", board.pending.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/lpsi_pkg.sv
sv/lpsi_div.sv
sv/lpsi_queue.sv
sv/lpsi_front.sv
sv/lpsi_back.sv
sv/laser_point_to_sample_interpolator_core.sv
test/laser_point_to_sample_interpolator_core_tb.sv
